// ===== rtl/core/ssw_pkg.sv =====
package ssw_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [DATA_W-1:0] TIMEOUT_RST = 32'd1000;

  // register index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_SESSION_TIMEOUT = 1'b0
  } ssw_reg_t;

  typedef enum logic [2:0] {
    KIND_LATCH    = 3'd0,
    KIND_CLEAR    = 3'd1,
    KIND_ENABLE   = 3'd2,
    KIND_ACTIVITY = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_MONITOR  = 3'd5
  } ssw_kind_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [DATA_W-1:0] now_ms;
    logic              motion_stopped;
    logic              arm_idle;
    logic              motion_moving;
    logic              arm_expanded;
  } ssw_item_t;

  typedef struct packed {
    logic              stop_motion;
    logic              stop_arm;
    logic              watchdog_error;
    logic              clear_ok;
    logic              estop_active;
    logic              session_active;
    logic              risk_now;
    logic [DATA_W-1:0] risk_events;
    logic [DATA_W-1:0] watchdog_events;
  } ssw_result_t;

  // handshake between input stage and core
  typedef struct packed {
    logic advance;
  } ssw_stage_ctl_t;

endpackage

// ===== rtl/core/ssw_in_if.sv =====
interface ssw_in_if;
  import ssw_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [DATA_W-1:0] now_ms;
  logic              motion_stopped;
  logic              arm_idle;
  logic              motion_moving;
  logic              arm_expanded;

  modport source (
    output valid, kind, now_ms, motion_stopped, arm_idle, motion_moving, arm_expanded,
    input  ready
  );

  modport sink (
    input  valid, kind, now_ms, motion_stopped, arm_idle, motion_moving, arm_expanded,
    output ready
  );
endinterface

interface ssw_out_if;
  import ssw_pkg::*;

  logic              valid;
  logic              ready;
  logic              stop_motion;
  logic              stop_arm;
  logic              watchdog_error;
  logic              clear_ok;
  logic              estop_active;
  logic              session_active;
  logic              risk_now;
  logic [DATA_W-1:0] risk_events;
  logic [DATA_W-1:0] watchdog_events;

  modport source (
    output valid, stop_motion, stop_arm, watchdog_error, clear_ok, estop_active,
           session_active, risk_now, risk_events, watchdog_events,
    input  ready
  );

  modport sink (
    input  valid, stop_motion, stop_arm, watchdog_error, clear_ok, estop_active,
           session_active, risk_now, risk_events, watchdog_events,
    output ready
  );
endinterface

// ===== rtl/core/ssw_cfg.sv =====
module ssw_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ssw_pkg::DATA_W-1:0]       pwdata,
  output logic [ssw_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output logic [ssw_pkg::DATA_W-1:0]       timeout_ms
);
  import ssw_pkg::*;

  logic [DATA_W-1:0] timeout_r;
  logic [DATA_W-1:0] timeout_nxt;
  logic              hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_ADDR_W-1:2] == REG_SESSION_TIMEOUT);

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && pready && hit) begin
      timeout_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign prdata     = hit ? timeout_r : '0;
  assign timeout_ms = timeout_r;

endmodule

// ===== rtl/core/ssw_in_reg.sv =====
module ssw_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  ssw_in_if.sink              in_ch,
  input  logic                advance,
  output ssw_pkg::ssw_item_t  item,
  output logic                item_valid
);
  import ssw_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  ssw_item_t item_r;
  logic      fire;

  // refill in the same cycle the held item moves on
  assign in_ch.ready = !valid_r || advance;
  assign fire        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item_r.kind           <= in_ch.kind;
      item_r.now_ms         <= in_ch.now_ms;
      item_r.motion_stopped <= in_ch.motion_stopped;
      item_r.arm_idle       <= in_ch.arm_idle;
      item_r.motion_moving  <= in_ch.motion_moving;
      item_r.arm_expanded   <= in_ch.arm_expanded;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

// ===== rtl/core/ssw_core.sv =====
module ssw_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssw_pkg::ssw_item_t           item,
  input  logic                         item_valid,
  input  logic [ssw_pkg::DATA_W-1:0]   timeout_ms,
  output ssw_pkg::ssw_stage_ctl_t      ctl,
  ssw_out_if.source                    out_ch
);
  import ssw_pkg::*;

  logic              estop_r,    estop_nxt;
  logic              session_r,  session_nxt;
  logic              fired_r,    fired_nxt;
  logic              risk_r,     risk_nxt;
  logic [DATA_W-1:0] last_act_r, last_act_nxt;
  logic [DATA_W-1:0] risk_cnt_r, risk_cnt_nxt;
  logic [DATA_W-1:0] wd_cnt_r,   wd_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  ssw_result_t       res_r,       res_nxt;

  logic              advance;
  logic [DATA_W-1:0] elapsed;
  logic              wd_fire;
  logic              risky;

  assign advance     = item_valid && (!out_valid_r || out_ch.ready);
  assign ctl.advance = advance;

  // wrap-safe: modulo 2^32 difference
  assign elapsed = item.now_ms - last_act_r;
  assign wd_fire = session_r && !fired_r && (elapsed > timeout_ms);
  assign risky   = item.motion_moving && item.arm_expanded;

  always_comb begin
    estop_nxt    = estop_r;
    session_nxt  = session_r;
    fired_nxt    = fired_r;
    risk_nxt     = risk_r;
    last_act_nxt = last_act_r;
    risk_cnt_nxt = risk_cnt_r;
    wd_cnt_nxt   = wd_cnt_r;
    res_nxt      = '0;

    case (item.kind)
      KIND_LATCH: begin
        estop_nxt           = 1'b1;
        res_nxt.stop_motion = 1'b1;
        res_nxt.stop_arm    = 1'b1;
      end
      KIND_CLEAR: begin
        if (!estop_r) begin
          res_nxt.clear_ok = 1'b1;
        end else if (item.motion_stopped && item.arm_idle) begin
          estop_nxt        = 1'b0;
          res_nxt.clear_ok = 1'b1;
        end
      end
      KIND_ENABLE: begin
        session_nxt  = 1'b1;
        fired_nxt    = 1'b0;
        last_act_nxt = item.now_ms;
      end
      KIND_ACTIVITY: begin
        if (session_r) begin
          last_act_nxt = item.now_ms;
          fired_nxt    = 1'b0;
        end
      end
      KIND_TICK: begin
        if (wd_fire) begin
          res_nxt.stop_arm       = 1'b1;
          res_nxt.watchdog_error = 1'b1;
          fired_nxt              = 1'b1;
          session_nxt            = 1'b0;
          wd_cnt_nxt             = wd_cnt_r + 1'b1;
        end
      end
      KIND_MONITOR: begin
        if (risky && !risk_r) begin
          risk_cnt_nxt = risk_cnt_r + 1'b1;
        end
        risk_nxt = risky;
      end
      default: begin
      end
    endcase

    res_nxt.estop_active    = estop_nxt;
    res_nxt.session_active  = session_nxt;
    res_nxt.risk_now        = risk_nxt;
    res_nxt.risk_events     = risk_cnt_nxt;
    res_nxt.watchdog_events = wd_cnt_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      estop_r     <= 1'b0;
      session_r   <= 1'b0;
      fired_r     <= 1'b0;
      risk_r      <= 1'b0;
      last_act_r  <= '0;
      risk_cnt_r  <= '0;
      wd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        estop_r    <= estop_nxt;
        session_r  <= session_nxt;
        fired_r    <= fired_nxt;
        risk_r     <= risk_nxt;
        last_act_r <= last_act_nxt;
        risk_cnt_r <= risk_cnt_nxt;
        wd_cnt_r   <= wd_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.stop_motion     = res_r.stop_motion;
  assign out_ch.stop_arm        = res_r.stop_arm;
  assign out_ch.watchdog_error  = res_r.watchdog_error;
  assign out_ch.clear_ok        = res_r.clear_ok;
  assign out_ch.estop_active    = res_r.estop_active;
  assign out_ch.session_active  = res_r.session_active;
  assign out_ch.risk_now        = res_r.risk_now;
  assign out_ch.risk_events     = res_r.risk_events;
  assign out_ch.watchdog_events = res_r.watchdog_events;

  // a result reflects the state the core holds once it is loaded
  a_res_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (res_r.estop_active == estop_r) && (res_r.session_active == session_r)
                && (res_r.watchdog_events == wd_cnt_r))
    else $error("result register out of step with supervisor state");

  a_wd_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item.kind == KIND_TICK && wd_fire) |=> (wd_cnt_r == $past(wd_cnt_r) + 1'b1))
    else $error("watchdog firing not counted");

  a_wd_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.watchdog_error) |-> (res_r.stop_arm && !res_r.session_active))
    else $error("watchdog fired without stopping arm and ending session");

  a_latch_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.stop_motion) |-> res_r.estop_active)
    else $error("stop issued without estop latched");

  a_clear_ok_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.clear_ok) |-> !res_r.estop_active)
    else $error("clear reported while estop still latched");

endmodule

// ===== rtl/core/safety_supervisor_watchdog.sv =====
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_ch.ready keeps the result register free; the
//   input register refills as its item moves on.
// rst_n (synchronous, active low) clears the estop, session, watchdog and risk flags,
//   the last-activity time and both counters, and sets the timeout to 1000 ms.
module safety_supervisor_watchdog (
  input  logic                           clk,
  input  logic                           rst_n,
  ssw_in_if.sink                         in_ch,
  ssw_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ssw_pkg::DATA_W-1:0]     pwdata,
  output logic [ssw_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import ssw_pkg::*;

  logic [DATA_W-1:0] timeout_ms;
  ssw_item_t         item;
  logic              item_valid;
  ssw_stage_ctl_t    ctl;

  ssw_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .timeout_ms (timeout_ms)
  );

  ssw_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (ctl.advance),
    .item       (item),
    .item_valid (item_valid)
  );

  ssw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .timeout_ms (timeout_ms),
    .ctl        (ctl),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/tb_safety_supervisor_watchdog.sv =====
module tb_safety_supervisor_watchdog;
  import ssw_pkg::*;

  // kinds outside the decoded set; the block must leave its state alone
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = {REG_SESSION_TIMEOUT, 2'b00};

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ssw_in_if  in_ch();
  ssw_out_if out_ch();

  safety_supervisor_watchdog u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // supervisor state as the block should hold it
  logic        sv_estop;
  logic        sv_session;
  logic        sv_fired;
  logic        sv_risk;
  logic [31:0] sv_last_act;
  logic [31:0] sv_risk_cnt;
  logic [31:0] sv_wd_cnt;
  logic [31:0] sv_timeout;

  ssw_result_t pending_results[$];

  int unsigned err_count;
  int unsigned n_events;
  int unsigned n_results;
  int unsigned n_fired;
  int unsigned n_cleared;
  int unsigned n_refused;
  int unsigned tx_max;
  int unsigned rx_max;
  logic        rx_hold;
  event        hold_ev;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("status: fail");
    $finish;
  end

  function automatic ssw_result_t predict_event(ssw_item_t ev);
    ssw_result_t r;
    logic        risky;
    logic [31:0] elapsed;
    r = '0;
    case (ev.kind)
      KIND_LATCH: begin
        sv_estop = 1'b1;
        r.stop_motion = 1'b1;
        r.stop_arm = 1'b1;
      end
      KIND_CLEAR: begin
        if (!sv_estop) begin
          r.clear_ok = 1'b1;
        end else if (ev.motion_stopped && ev.arm_idle) begin
          sv_estop = 1'b0;
          r.clear_ok = 1'b1;
          n_cleared++;
        end else begin
          n_refused++;
        end
      end
      KIND_ENABLE: begin
        sv_session = 1'b1;
        sv_fired = 1'b0;
        sv_last_act = ev.now_ms;
      end
      KIND_ACTIVITY: begin
        if (sv_session) begin
          sv_last_act = ev.now_ms;
          sv_fired = 1'b0;
        end
      end
      KIND_TICK: begin
        elapsed = ev.now_ms - sv_last_act;
        if (sv_session && !sv_fired && elapsed > sv_timeout) begin
          r.stop_arm = 1'b1;
          r.watchdog_error = 1'b1;
          sv_fired = 1'b1;
          sv_session = 1'b0;
          sv_wd_cnt = sv_wd_cnt + 32'd1;
          n_fired++;
        end
      end
      KIND_MONITOR: begin
        risky = ev.motion_moving & ev.arm_expanded;
        if (risky && !sv_risk) sv_risk_cnt = sv_risk_cnt + 32'd1;
        sv_risk = risky;
      end
      default: ;
    endcase
    r.estop_active = sv_estop;
    r.session_active = sv_session;
    r.risk_now = sv_risk;
    r.risk_events = sv_risk_cnt;
    r.watchdog_events = sv_wd_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    ssw_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        check_field("stop_motion", want.stop_motion, out_ch.stop_motion);
        check_field("stop_arm", want.stop_arm, out_ch.stop_arm);
        check_field("watchdog_error", want.watchdog_error, out_ch.watchdog_error);
        check_field("clear_ok", want.clear_ok, out_ch.clear_ok);
        check_field("estop_active", want.estop_active, out_ch.estop_active);
        check_field("session_active", want.session_active, out_ch.session_active);
        check_field("risk_now", want.risk_now, out_ch.risk_now);
        check_field("risk_events", want.risk_events, out_ch.risk_events);
        check_field("watchdog_events", want.watchdog_events, out_ch.watchdog_events);
      end
    end
  end

  // result receiver: random stall after each item, plus the long hold
  initial begin
    int unsigned rx_wait;
    int unsigned w;
    out_ch.ready = 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        rx_wait = 0;
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) w = $urandom_range(0, rx_max);
        else if (rx_wait > 0) w = rx_wait - 1;
        else w = 0;
        rx_wait = w;
        out_ch.ready <= (w == 0) && !rx_hold;
      end
    end
  end

  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // flags: {motion_stopped, arm_idle, motion_moving, arm_expanded}
  task automatic send_event(input logic [2:0] k, input logic [31:0] t, input logic [3:0] f);
    ssw_item_t   ev;
    int unsigned gap;
    ev.kind = k;
    ev.now_ms = t;
    {ev.motion_stopped, ev.arm_idle, ev.motion_moving, ev.arm_expanded} = f;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= ev.kind;
    in_ch.now_ms <= ev.now_ms;
    in_ch.motion_stopped <= ev.motion_stopped;
    in_ch.arm_idle <= ev.arm_idle;
    in_ch.motion_moving <= ev.motion_moving;
    in_ch.arm_expanded <= ev.arm_expanded;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_event(ev));
    n_events++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the timeout over the config port, then read it back
  task automatic program_timeout(input logic [31:0] val);
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sv_timeout = val;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("session_timeout_ms readback", val, got);
  endtask

  task automatic test_directed;
    tx_max = 3;
    rx_max <= 3;
    send_event(KIND_MONITOR, 32'd0, 4'b0011);
    send_event(KIND_MONITOR, 32'd0, 4'b1111);
    send_event(KIND_MONITOR, 32'd0, 4'b1110);
    send_event(KIND_MONITOR, 32'd0, 4'b0001);
    send_event(KIND_MONITOR, 32'd0, 4'b0011);
    send_event(KIND_CLEAR, 32'd7, 4'b0000);
    send_event(KIND_LATCH, 32'hFFFF_FFFF, 4'b1111);
    send_event(KIND_CLEAR, 32'd8, 4'b1000);
    send_event(KIND_CLEAR, 32'd9, 4'b0100);
    send_event(KIND_CLEAR, 32'd10, 4'b1100);
    send_event(KIND_ACTIVITY, 32'd500, 4'b0000);
    send_event(KIND_TICK, 32'd5000, 4'b0000);
    send_event(KIND_SPARE_A, 32'hFFFF_FFFF, 4'b1111);
    send_event(KIND_SPARE_B, 32'd0, 4'b0000);
    // session across the 32-bit wrap: exactly the timeout does not fire
    send_event(KIND_ENABLE, 32'hFFFF_FF00, 4'b0000);
    send_event(KIND_ACTIVITY, 32'hFFFF_FF10, 4'b0000);
    send_event(KIND_TICK, 32'hFFFF_FF10 + 32'd1000, 4'b0000);
    send_event(KIND_TICK, 32'hFFFF_FF10 + 32'd1001, 4'b0000);
    send_event(KIND_TICK, 32'h0000_5000, 4'b0000);
    send_event(KIND_ACTIVITY, 32'h0000_5001, 4'b0000);
    send_event(KIND_ENABLE, 32'd100, 4'b0000);
    send_event(KIND_TICK, 32'd1101, 4'b0000);
    send_event(KIND_ENABLE, 32'd2000, 4'b0000);
    send_event(KIND_LATCH, 32'd2500, 4'b0000);
    send_event(KIND_TICK, 32'd3001, 4'b1010);
    send_event(KIND_CLEAR, 32'd3002, 4'b1111);
    drain();
  endtask

  task automatic random_events(input int unsigned count);
    int unsigned r;
    int unsigned step;
    logic [2:0]  k;
    logic [31:0] t;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      step = (sv_timeout > 4000) ? 1000 : sv_timeout / 3 + 1;
      clock_ms = clock_ms + $urandom_range(0, step);
      t = clock_ms;
      if (r < 8) k = KIND_LATCH;
      else if (r < 20) k = KIND_CLEAR;
      else if (r < 30) k = KIND_ENABLE;
      else if (r < 48) k = KIND_ACTIVITY;
      else if (r < 73) begin
        k = KIND_TICK;
        // land on the timeout edge much of the time
        if ($urandom_range(0, 9) < 4) begin
          t = sv_last_act + sv_timeout + $urandom_range(0, 2) - 1;
          clock_ms = t;
        end
      end else if (r < 92) k = KIND_MONITOR;
      else if (r < 96) k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      else begin
        k = 3'($urandom_range(0, 7));
        t = $urandom;
      end
      // bias try-clear towards the clearing condition
      if (k == KIND_CLEAR && $urandom_range(0, 1)) send_event(k, t, {2'b11, 2'($urandom)});
      else send_event(k, t, 4'($urandom));
    end
  endtask

  task automatic test_timeout_settings;
    logic [31:0] settings[6];
    settings[0] = TIMEOUT_RST;
    settings[1] = 32'd0;
    settings[2] = 32'hFFFF_FFFF;
    settings[3] = 32'd1;
    settings[4] = $urandom_range(2, 5000);
    settings[5] = $urandom;
    clock_ms = $urandom;
    for (int p = 0; p < 6; p++) begin
      program_timeout(settings[p]);
      // alternate busy stretches with heavy idling on either side
      tx_max = (p % 3 == 1) ? 0 : 15;
      rx_max <= (p % 3 == 2) ? 0 : 15;
      random_events(150);
      tx_max = 15;
      rx_max <= 15;
      random_events(10);
      drain();
    end
  endtask

  task automatic test_backpressure;
    program_timeout(32'd50);
    tx_max = 0;
    rx_max <= 2;
    -> hold_ev;
    random_events(60);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LATCH;
    in_ch.now_ms = '0;
    in_ch.motion_stopped = 1'b0;
    in_ch.arm_idle = 1'b0;
    in_ch.motion_moving = 1'b0;
    in_ch.arm_expanded = 1'b0;
    sv_estop = 1'b0;
    sv_session = 1'b0;
    sv_fired = 1'b0;
    sv_risk = 1'b0;
    sv_last_act = '0;
    sv_risk_cnt = '0;
    sv_wd_cnt = '0;
    sv_timeout = TIMEOUT_RST;
    err_count = 0;
    n_events = 0;
    n_results = 0;
    n_fired = 0;
    n_cleared = 0;
    n_refused = 0;
    tx_max = 15;
    rx_max = 15;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_timeout_settings();
    test_backpressure();

    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      err_count++;
    end
    $display("Ran %0d events / %0d results over timeouts 1000, 0, max, 1, two random, 50",
             n_events, n_results);
    $display("Watchdog fired %0d times; estop cleared %0d, refused %0d; output held %0d cycles",
             n_fired, n_cleared, n_refused, HOLD_CYCLES);
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssw_pkg.sv
rtl/core/ssw_in_if.sv
rtl/core/ssw_cfg.sv
rtl/core/ssw_in_reg.sv
rtl/core/ssw_core.sv
rtl/core/safety_supervisor_watchdog.sv
tb/tb_safety_supervisor_watchdog.sv
